FILE: src/tcc_pkg.sv
// ============================================================================
// tcc_pkg - shared types and constants for the text cell console
// Field widths, register codes, command and operation codes, queue entry
// and status types used by the front end, the queue and the back end.
// ============================================================================
package tcc_pkg;

    // Field widths of the item and result channels
    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int CLR_W    = 4;
    localparam int COLIN_W  = 6;
    localparam int ROWIN_W  = 5;
    localparam int CELL_W   = CHAR_W + 2 * CLR_W;

    // Configuration register widths and reset values
    localparam int COLS_W   = 7;
    localparam int ROWS_W   = 6;
    localparam logic [COLS_W-1:0] COLUMNS_RST = 7'd50;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd15;
    localparam logic [CLR_W-1:0]  DFORE_RST   = 4'd15;
    localparam logic [CLR_W-1:0]  DBACK_RST   = 4'd0;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Default geometry limits
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 32;

    // Widest column and row carried in a queue entry (covers the largest geometry)
    localparam int OP_COL_W = 8;
    localparam int OP_ROW_W = 7;

    // Character and colour constants
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CLR_W-1:0]  WHITE_FG     = 4'hF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register index
    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_DFORE   = 2'd2,
        REG_DBACK   = 2'd3
    } t_reg;

    // Command codes on the item channel
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 3'd0,
        CMD_PUT    = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_SETCUR = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        K_WRITE,
        K_NEWLINE,
        K_PUT,
        K_CLEAR,
        K_DELETE,
        K_SETCUR,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CHAR_W-1:0]    ch;
        logic [CLR_W-1:0]     fg;
        logic [CLR_W-1:0]     bg;
        logic [OP_COL_W-1:0]  col;
        logic [OP_ROW_W-1:0]  row;
    } t_op;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_SCROLL,
        BS_FILL,
        BS_CLEAR
    } t_bstate;

endpackage

FILE: src/tcc_if.sv
// ============================================================================
// tcc_if - item and result channels of the text cell console
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface tcc_in_if;
    import tcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [CLR_W-1:0]   fg_color;
    logic [CLR_W-1:0]   bg_color;
    logic [COLIN_W-1:0] col_in;
    logic [ROWIN_W-1:0] row_in;

    modport source (
        output valid, cmd, char_code, fg_color, bg_color, col_in, row_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, char_code, fg_color, bg_color, col_in, row_in,
        output ready
    );
endinterface

interface tcc_out_if;
    import tcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLIN_W-1:0] cursor_col;
    logic [ROWIN_W-1:0] cursor_row;
    logic [CHAR_W-1:0]  cell_char;
    logic [CLR_W-1:0]   cell_fg;
    logic [CLR_W-1:0]   cell_bg;
    logic               scrolled;

    modport source (
        output valid, cursor_col, cursor_row, cell_char, cell_fg, cell_bg, scrolled,
        input  ready
    );
    modport sink (
        input  valid, cursor_col, cursor_row, cell_char, cell_fg, cell_bg, scrolled,
        output ready
    );
endinterface

FILE: src/tcc_front.sv
// ============================================================================
// tcc_front - command intake and classification
// Takes command transactions, range-checks coordinates against the active
// geometry, saturates set-cursor targets and pushes one operation per item.
// ============================================================================
module tcc_front #(
    parameter int MAX_COLUMNS = tcc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcc_pkg::DEF_MAX_ROWS
) (
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  i_nc,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     i_nr,
    tcc_in_if.sink                            i_item,
    input  tcc_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output tcc_pkg::t_op                      o_op
);
    import tcc_pkg::*;

    localparam int NCW = $clog2(MAX_COLUMNS + 1);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int XCW = OP_COL_W + 1;
    localparam int XRW = OP_ROW_W + 1;

    logic                col_ok;
    logic                row_ok;
    logic [OP_COL_W-1:0] col_sat;
    logic [OP_ROW_W-1:0] row_sat;

    // Accept whenever the queue has room
    assign i_item.ready = !i_q_stat.full;
    assign o_push       = i_item.valid && i_item.ready;

    // Range checks against the active area
    always_comb begin
        col_ok  = XCW'(i_item.col_in) < XCW'(i_nc);
        row_ok  = XRW'(i_item.row_in) < XRW'(i_nr);
        col_sat = col_ok ? OP_COL_W'(i_item.col_in) : OP_COL_W'(i_nc - NCW'(1));
        row_sat = row_ok ? OP_ROW_W'(i_item.row_in) : OP_ROW_W'(i_nr - NRW'(1));
    end

    // Classify the command
    always_comb begin
        o_op.ch  = i_item.char_code;
        o_op.fg  = i_item.fg_color;
        o_op.bg  = i_item.bg_color;
        o_op.col = OP_COL_W'(i_item.col_in);
        o_op.row = OP_ROW_W'(i_item.row_in);
        case (t_cmd'(i_item.cmd))
            CMD_WRITE: begin
                o_op.kind = (i_item.char_code == NEWLINE_CHAR) ? K_NEWLINE : K_WRITE;
            end
            CMD_PUT: begin
                o_op.kind = (col_ok && row_ok) ? K_PUT : K_NOP;
            end
            CMD_CLEAR: begin
                o_op.kind = K_CLEAR;
            end
            CMD_DELETE: begin
                o_op.kind = K_DELETE;
            end
            CMD_SETCUR: begin
                o_op.kind = K_SETCUR;
                o_op.col  = col_sat;
                o_op.row  = row_sat;
            end
            CMD_READ: begin
                o_op.kind = (col_ok && row_ok) ? K_READ : K_NOP;
            end
            default: begin
                o_op.kind = K_NOP;
            end
        endcase
    end

endmodule

FILE: src/tcc_queue.sv
// ============================================================================
// tcc_queue - short operation queue between front and back
// Two-entry FIFO; lets the front keep taking commands while the back is busy.
// ============================================================================
module tcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcc_pkg::t_op     i_op,
    input  logic             i_pop,
    output tcc_pkg::t_op     o_op,
    output tcc_pkg::t_q_stat o_stat
);
    import tcc_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_op         = r_slot[r_rp];
    assign o_stat.valid = r_cnt != '0;
    assign o_stat.full  = r_cnt == QCNT_W'(QUEUE_DEPTH);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Hold entry payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

FILE: src/tcc_back.sv
// ============================================================================
// tcc_back - command execution, cell store and result register
// Owns the cursor and the cell memory. Simple commands finish in the idle state;
// read waits for the memory, clear and scroll walk the store cell by cell.
// ============================================================================
module tcc_back #(
    parameter int MAX_COLUMNS = tcc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcc_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  i_nc,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     i_nr,
    input  logic [tcc_pkg::CLR_W-1:0]         i_def_fore,
    input  logic [tcc_pkg::CLR_W-1:0]         i_def_back,
    input  tcc_pkg::t_q_stat                  i_q_stat,
    input  tcc_pkg::t_op                      i_q_op,
    output logic                              o_q_pop,
    tcc_out_if.source                         o_res
);
    import tcc_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int NCW   = $clog2(MAX_COLUMNS + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;

    // Sequencer and walk state
    t_bstate             r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_wc, n_wc;
    logic [RW-1:0]       r_wr, n_wr;
    logic                r_wb_valid, n_wb_valid;
    logic [AW-1:0]       r_wb_addr, n_wb_addr;

    // Cell memory
    logic [CELL_W-1:0]   mem [DEPTH];
    logic [CELL_W-1:0]   r_rdata;
    logic                w_en;
    logic [AW-1:0]       w_addr;
    logic [CELL_W-1:0]   w_data;
    logic [AW-1:0]       rd_addr;

    // Result register
    logic                r_out_valid;
    logic [COLIN_W-1:0]  r_o_col;
    logic [ROWIN_W-1:0]  r_o_row;
    logic [CELL_W-1:0]   r_o_cell;
    logic                r_o_scr;

    // Decode
    t_kind               kind;
    logic [CW-1:0]       nc_last;
    logic [RW-1:0]       nr_last;
    logic [CW-1:0]       cc;
    logic [RW-1:0]       cr;
    logic [NCW-1:0]      col_inc;
    logic [NRW-1:0]      row_inc;
    logic                wrap;
    logic                over;
    logic [RW-1:0]       nl_row;
    logic [CW-1:0]       x_col;
    logic [RW-1:0]       x_row;
    logic                x_scroll;
    logic                slot_free;
    logic                start;
    logic                last_col;
    logic                last_copy;
    logic                last_row;
    logic                emit;
    logic                emit_scr;
    logic [CELL_W-1:0]   emit_cell;
    logic [CELL_W-1:0]   blank_cell;

    // Clamp cursor and work out where each operation leaves it
    always_comb begin
        kind      = i_q_op.kind;
        nc_last   = CW'(i_nc - NCW'(1));
        nr_last   = RW'(i_nr - NRW'(1));
        cc        = (NCW'(r_col) >= i_nc) ? nc_last : r_col;
        cr        = (NRW'(r_row) >= i_nr) ? nr_last : r_row;
        col_inc   = NCW'(cc) + NCW'(1);
        row_inc   = NRW'(cr) + NRW'(1);
        wrap      = col_inc >= i_nc;
        over      = row_inc >= i_nr;
        nl_row    = over ? nr_last : row_inc[RW-1:0];
        slot_free = !r_out_valid || o_res.ready;
        start     = (r_state == BS_IDLE) && i_q_stat.valid && slot_free;
        last_col  = r_wc == nc_last;
        last_copy = (NRW'(r_wr) + NRW'(2)) == i_nr;
        last_row  = r_wr == nr_last;
        blank_cell = {i_def_back, i_def_fore, SPACE_CHAR};

        x_col    = r_col;
        x_row    = r_row;
        x_scroll = 1'b0;
        case (kind)
            K_WRITE: begin
                if (wrap) begin
                    x_col    = '0;
                    x_row    = nl_row;
                    x_scroll = over;
                end else begin
                    x_col = col_inc[CW-1:0];
                    x_row = cr;
                end
            end
            K_NEWLINE: begin
                x_col    = '0;
                x_row    = nl_row;
                x_scroll = over;
            end
            K_CLEAR: begin
                x_col = '0;
                x_row = '0;
            end
            K_DELETE: begin
                x_col = (cc != '0) ? cc - CW'(1) : cc;
                x_row = cr;
            end
            K_SETCUR: begin
                x_col = i_q_op.col[CW-1:0];
                x_row = i_q_op.row[RW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (start) begin
                    if (kind == K_READ) begin
                        n_state = BS_READ;
                    end else if (kind == K_CLEAR) begin
                        n_state = BS_CLEAR;
                    end else if (kind inside {K_WRITE, K_NEWLINE} && x_scroll) begin
                        n_state = (i_nr == NRW'(1)) ? BS_FILL : BS_SCROLL;
                    end
                end
            end
            BS_READ: begin
                n_state = BS_IDLE;
            end
            BS_SCROLL: begin
                if (last_col && last_copy) begin
                    n_state = BS_FILL;
                end
            end
            BS_FILL: begin
                if (!r_wb_valid && last_col) begin
                    n_state = BS_IDLE;
                end
            end
            BS_CLEAR: begin
                if (last_col && last_row) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Memory ports, walk counters and result
    always_comb begin
        o_q_pop    = start;
        n_col      = r_col;
        n_row      = r_row;
        n_wc       = r_wc;
        n_wr       = r_wr;
        n_wb_valid = 1'b0;
        n_wb_addr  = {r_wr, r_wc};
        w_en       = 1'b0;
        w_addr     = r_wb_addr;
        w_data     = r_rdata;
        rd_addr    = {r_wr + RW'(1), r_wc};
        emit       = 1'b0;
        emit_scr   = 1'b0;
        emit_cell  = '0;
        case (r_state)
            BS_IDLE: begin
                if (start) begin
                    n_col   = x_col;
                    n_row   = x_row;
                    n_wc    = '0;
                    n_wr    = '0;
                    rd_addr = {i_q_op.row[RW-1:0], i_q_op.col[CW-1:0]};
                    case (kind)
                        K_WRITE: begin
                            w_en   = 1'b1;
                            w_addr = {cr, cc};
                            w_data = {i_q_op.bg, i_q_op.fg, i_q_op.ch};
                        end
                        K_PUT: begin
                            w_en   = 1'b1;
                            w_addr = {i_q_op.row[RW-1:0], i_q_op.col[CW-1:0]};
                            w_data = {i_q_op.bg, i_q_op.fg, i_q_op.ch};
                        end
                        K_DELETE: begin
                            w_en   = cc != '0;
                            w_addr = {cr, x_col};
                            w_data = blank_cell;
                        end
                        default: begin
                        end
                    endcase
                    emit = (kind != K_READ) && (kind != K_CLEAR) && !x_scroll;
                end
            end
            BS_READ: begin
                emit      = 1'b1;
                emit_cell = r_rdata;
            end
            BS_SCROLL: begin
                // Copy the row below up; the write lands in the cycle after the read
                n_wb_valid = 1'b1;
                w_en       = r_wb_valid;
                if (last_col) begin
                    n_wc = '0;
                    n_wr = r_wr + RW'(1);
                end else begin
                    n_wc = r_wc + CW'(1);
                end
            end
            BS_FILL: begin
                // Finish the last copy first, then blank the bottom row
                w_en = 1'b1;
                if (!r_wb_valid) begin
                    w_addr = {nr_last, r_wc};
                    w_data = {i_def_back, WHITE_FG, SPACE_CHAR};
                    n_wc   = last_col ? '0 : r_wc + CW'(1);
                    emit     = last_col;
                    emit_scr = 1'b1;
                end
            end
            BS_CLEAR: begin
                w_en   = 1'b1;
                w_addr = {r_wr, r_wc};
                w_data = blank_cell;
                if (last_col) begin
                    n_wc = '0;
                    n_wr = r_wr + RW'(1);
                end else begin
                    n_wc = r_wc + CW'(1);
                end
                emit = last_col && last_row;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_wb_valid <= n_wb_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk counters and result payload
    always_ff @(posedge i_clk) begin
        r_wc      <= n_wc;
        r_wr      <= n_wr;
        r_wb_addr <= n_wb_addr;
        if (emit) begin
            r_o_col  <= COLIN_W'(n_col);
            r_o_row  <= ROWIN_W'(n_row);
            r_o_cell <= emit_cell;
            r_o_scr  <= emit_scr;
        end
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[rd_addr];
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_col = r_o_col;
    assign o_res.cursor_row = r_o_row;
    assign o_res.cell_char  = r_o_cell[CHAR_W-1:0];
    assign o_res.cell_fg    = r_o_cell[CHAR_W +: CLR_W];
    assign o_res.cell_bg    = r_o_cell[CHAR_W+CLR_W +: CLR_W];
    assign o_res.scrolled   = r_o_scr;

endmodule

FILE: src/text_cell_console_engine_core.sv
// ============================================================================
// text_cell_console_engine_core - character-cell text console
// Top level: APB register file, command front end, queue and back end.
// ============================================================================
// Each command returns exactly one result, in order. Put, set cursor,
// delete, unknown commands and a write or newline that does not scroll
// finish in the idle state of the back end; a read waits for the
// registered memory read. Clear and a scrolling write or newline both pass
// through the single write port of the cell memory,
// which they sweep one cell per cycle. A two-entry queue keeps the command
// port open while a long command runs. The cell store is not cleared by
// reset: issue a clear before reading or scrolling cells.
module text_cell_console_engine_core #(
    parameter int MAX_COLUMNS = tcc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tcc_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    tcc_in_if.sink                            i_item,
    tcc_out_if.source                         o_res
);
    import tcc_pkg::*;

    localparam int NCW = $clog2(MAX_COLUMNS + 1);
    localparam int NRW = $clog2(MAX_ROWS + 1);

    logic [COLS_W-1:0] r_columns;
    logic [ROWS_W-1:0] r_rows;
    logic [CLR_W-1:0]  r_dfore;
    logic [CLR_W-1:0]  r_dback;
    logic [NCW-1:0]    nc;
    logic [NRW-1:0]    nr;
    logic              wr_en;
    t_reg              reg_idx;
    t_q_stat           q_stat;
    t_op               f_op;
    t_op               q_op;
    logic              q_push;
    logic              q_pop;

    // Register access
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RST;
            r_rows    <= ROWS_RST;
            r_dfore   <= DFORE_RST;
            r_dback   <= DBACK_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COLUMNS: r_columns <= pwdata[COLS_W-1:0];
                REG_ROWS:    r_rows    <= pwdata[ROWS_W-1:0];
                REG_DFORE:   r_dfore   <= pwdata[CLR_W-1:0];
                REG_DBACK:   r_dback   <= pwdata[CLR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COLUMNS: prdata = APB_DATA_W'(r_columns);
            REG_ROWS:    prdata = APB_DATA_W'(r_rows);
            REG_DFORE:   prdata = APB_DATA_W'(r_dfore);
            REG_DBACK:   prdata = APB_DATA_W'(r_dback);
            default:     prdata = '0;
        endcase
    end

    // Active geometry: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_columns == '0) begin
            nc = NCW'(1);
        end else if (32'(r_columns) > MAX_COLUMNS) begin
            nc = NCW'(MAX_COLUMNS);
        end else begin
            nc = NCW'(r_columns);
        end
        if (r_rows == '0) begin
            nr = NRW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(r_rows);
        end
    end

    tcc_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_nc     (nc),
        .i_nr     (nr),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_op     (f_op)
    );

    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_stat  (q_stat)
    );

    tcc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nc       (nc),
        .i_nr       (nr),
        .i_def_fore (r_dfore),
        .i_def_back (r_dback),
        .i_q_stat   (q_stat),
        .i_q_op     (q_op),
        .o_q_pop    (q_pop),
        .o_res      (o_res)
    );

    // The back end never takes an operation from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.valid)
        else $error("operation taken from empty queue");

    // An accepted transaction is visible to the back end on the next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |=> q_stat.valid)
        else $error("accepted transaction lost from queue");

    // A scrolling result never carries cell contents
    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.scrolled) |->
            (o_res.cell_char == '0 && o_res.cell_fg == '0 && o_res.cell_bg == '0))
        else $error("scrolled result carries cell data");

endmodule
